[sv/pffl_pkg.sv]
// ----------------------------------------------------------------------------
// pffl_pkg
// shared codes and controller/datapath handshake types for the frame allocator
// ----------------------------------------------------------------------------
package pffl_pkg;

  // operation codes
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_ADD     = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_FREE   = 2'd1;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd2;
  localparam logic [1:0] ST_NOT_RSV   = 2'd3;

  // per-frame kind codes
  localparam logic [1:0] KIND_RESERVED  = 2'd0;
  localparam logic [1:0] KIND_AVAILABLE = 2'd1;
  localparam logic [1:0] KIND_ALLOCATED = 2'd2;

  // reference count width
  localparam int RC_W = 16;

  // controller to datapath
  typedef struct packed {
    logic accept;    // input transfer, latch item and issue table reads
    logic clr;       // clear one frame state entry
    logic exec;      // apply the operation
    logic link2;     // write the old tail's forward link
    logic load_out;  // move the result into the output register
  } pffl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;    // clearing pass is at its last entry
    logic need_link2;  // add to a non-empty list needs a second link write
  } pffl_stat_t;

endpackage

[sv/pffl_ctrl.sv]
// ----------------------------------------------------------------------------
// pffl_ctrl
// sequencer for the frame allocator: clearing pass, per-item steps, result slot
// ----------------------------------------------------------------------------
module pffl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output pffl_pkg::pffl_cmd_t cmd,
  input  pffl_pkg::pffl_stat_t stat
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_LINK2,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.need_link2 ? S_LINK2 : S_DONE;
      end
      S_LINK2: begin
        cmd.link2 = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[sv/pffl_dp.sv]
// ----------------------------------------------------------------------------
// pffl_dp
// frame allocator datapath: link and frame state tables, list registers
// ----------------------------------------------------------------------------
module pffl_dp #(
  parameter int FRAME_COUNT = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pffl_pkg::pffl_cmd_t  cmd,
  output pffl_pkg::pffl_stat_t stat,
  input  logic [1:0]           in_op,
  input  logic [11:0]          in_frame_number,
  output logic [1:0]           out_status,
  output logic [11:0]          out_granted_frame,
  output logic [12:0]          out_free_count
);

  localparam int AW = $clog2(FRAME_COUNT);
  localparam int LW = $clog2(FRAME_COUNT + 1);
  localparam int MW = 2 + pffl_pkg::RC_W;
  localparam logic [LW-1:0] NIL = LW'(FRAME_COUNT);

  // forward links; backward links are never consulted and are not kept
  logic [LW-1:0] link_mem [0:FRAME_COUNT-1];
  // {kind, reference count}
  logic [MW-1:0] meta_mem [0:FRAME_COUNT-1];

  logic [LW-1:0] head_r, head_nxt;
  logic [LW-1:0] tail_r, tail_nxt;
  logic [LW-1:0] avail_r, avail_nxt;
  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] link_tail_r, link_tail_nxt;
  logic [1:0]    op_r;
  logic [AW-1:0] f_addr_r;
  logic          f_ok_r;
  logic [LW-1:0] link_rd_r;
  logic [MW-1:0] meta_rd_r;
  logic [1:0]    res_status_r, res_status_nxt;
  logic [11:0]   res_granted_r, res_granted_nxt;

  logic                    link_we, meta_we;
  logic [AW-1:0]           link_wa, meta_wa;
  logic [LW-1:0]           link_wd;
  logic [MW-1:0]           meta_wd;
  logic [1:0]              meta_kind;
  logic [pffl_pkg::RC_W-1:0] meta_rc, rc_dec;
  logic                    head_empty, tail_empty;
  logic [LW-1:0]           f_link;
  logic                    need_link2;

  assign meta_kind  = meta_rd_r[MW-1 -: 2];
  assign meta_rc    = meta_rd_r[pffl_pkg::RC_W-1:0];
  assign rc_dec     = meta_rc - pffl_pkg::RC_W'(1);
  assign head_empty = (avail_r == '0) || (head_r >= NIL);
  assign tail_empty = (avail_r == '0) || (tail_r >= NIL);
  assign f_link     = LW'(f_addr_r);

  assign stat.clr_last   = (clr_addr_r == AW'(FRAME_COUNT - 1));
  assign stat.need_link2 = need_link2;

  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    avail_nxt       = avail_r;
    link_tail_nxt   = link_tail_r;
    res_status_nxt  = res_status_r;
    res_granted_nxt = res_granted_r;
    link_we         = 1'b0;
    link_wa         = f_addr_r;
    link_wd         = NIL;
    meta_we         = 1'b0;
    meta_wa         = f_addr_r;
    meta_wd         = '0;
    need_link2      = 1'b0;
    if (cmd.clr) begin
      meta_we = 1'b1;
      meta_wa = clr_addr_r;
    end else if (cmd.link2) begin
      link_we = 1'b1;
      link_wa = link_tail_r;
      link_wd = f_link;
    end else if (cmd.exec) begin
      res_status_nxt  = pffl_pkg::ST_OK;
      res_granted_nxt = '0;
      case (op_r)
        pffl_pkg::OP_ALLOC: begin
          if (head_empty) begin
            res_status_nxt = pffl_pkg::ST_NO_FREE;
          end else begin
            // pop the head
            head_nxt = link_rd_r;
            if (link_rd_r >= NIL) begin
              tail_nxt = NIL;
            end
            link_we         = 1'b1;
            link_wa         = AW'(head_r);
            link_wd         = NIL;
            meta_we         = 1'b1;
            meta_wa         = AW'(head_r);
            meta_wd         = {pffl_pkg::KIND_ALLOCATED, pffl_pkg::RC_W'(1)};
            avail_nxt       = avail_r - LW'(1);
            res_granted_nxt = 12'(head_r);
          end
        end
        pffl_pkg::OP_RELEASE: begin
          if (!f_ok_r || meta_kind != pffl_pkg::KIND_ALLOCATED) begin
            res_status_nxt = pffl_pkg::ST_NOT_ALLOC;
          end else if (rc_dec != '0) begin
            meta_we = 1'b1;
            meta_wd = {pffl_pkg::KIND_ALLOCATED, rc_dec};
          end else begin
            // last reference gone, push at the head
            meta_we   = 1'b1;
            meta_wd   = {pffl_pkg::KIND_AVAILABLE, rc_dec};
            link_we   = 1'b1;
            link_wd   = head_empty ? NIL : head_r;
            if (head_empty) begin
              tail_nxt = f_link;
            end
            head_nxt  = f_link;
            avail_nxt = avail_r + LW'(1);
          end
        end
        pffl_pkg::OP_ADD: begin
          if (!f_ok_r || meta_kind != pffl_pkg::KIND_RESERVED) begin
            res_status_nxt = pffl_pkg::ST_NOT_RSV;
          end else begin
            // append at the tail
            meta_we = 1'b1;
            meta_wd = {pffl_pkg::KIND_AVAILABLE, meta_rc};
            link_we = 1'b1;
            link_wd = NIL;
            if (tail_empty) begin
              head_nxt = f_link;
            end else begin
              need_link2    = 1'b1;
              link_tail_nxt = AW'(tail_r);
            end
            tail_nxt  = f_link;
            avail_nxt = avail_r + LW'(1);
          end
        end
        default: begin
          res_status_nxt = pffl_pkg::ST_OK;
        end
      endcase
    end
  end

  // link table: one write, one registered read
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (cmd.accept) begin
      link_rd_r <= link_mem[AW'(head_r)];
    end
  end

  // frame state table: one write, one registered read
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
    if (cmd.accept) begin
      meta_rd_r <= meta_mem[AW'(in_frame_number)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= NIL;
      tail_r     <= NIL;
      avail_r    <= '0;
      clr_addr_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      avail_r <= avail_nxt;
      if (cmd.clr) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    link_tail_r   <= link_tail_nxt;
    res_status_r  <= res_status_nxt;
    res_granted_r <= res_granted_nxt;
    if (cmd.accept) begin
      op_r     <= in_op;
      f_addr_r <= AW'(in_frame_number);
      f_ok_r   <= (32'(in_frame_number) < 32'(FRAME_COUNT));
    end
    if (cmd.load_out) begin
      out_status        <= res_status_r;
      out_granted_frame <= res_granted_r;
      out_free_count    <= 13'(avail_r);
    end
  end

endmodule

[sv/page_frame_free_list_allocator_unit.sv]
// ----------------------------------------------------------------------------
// page_frame_free_list_allocator_unit
// page frame allocator over a linked free list: alloc, release, add frame
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_ready    in_op, in_frame_number
//  out_     output     out_valid / out_ready  out_status, out_granted_frame,
//                                             out_free_count
//
//  an item passes through accept, execute and result load; an add onto a
//  non-empty list adds a write of the old tail's link into the link table
//  one item at a time; the next transfer is taken once the result is in the
//  output register, even while that result still waits for out_ready
//  after reset a clearing pass walks all FRAME_COUNT entries of the frame
//  state table, with in_ready low
//  a stalled output holds the sequencer in its final step until the slot frees
//
module page_frame_free_list_allocator_unit #(
  parameter int FRAME_COUNT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [11:0] in_frame_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [11:0] out_granted_frame,
  output logic [12:0] out_free_count
);

  // command and status between sequencer and datapath
  pffl_pkg::pffl_cmd_t  cmd;
  pffl_pkg::pffl_stat_t stat;

  // sequencer: clear pass, accept, execute, tail link, result load
  pffl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // tables, list head/tail/count and result registers
  pffl_dp #(
    .FRAME_COUNT (FRAME_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_op             (in_op),
    .in_frame_number   (in_frame_number),
    .out_status        (out_status),
    .out_granted_frame (out_granted_frame),
    .out_free_count    (out_free_count)
  );

endmodule
